FILE: rtl/cpcc_pkg.sv
// ----------------------------------------------------------------------------
// cpcc_pkg
// Shared types, constants and rounding helpers for the circle contact pipe.
// ----------------------------------------------------------------------------
package cpcc_pkg;

    localparam int IN_W      = 320;
    localparam int OUT_W     = 168;
    localparam int SQ_STEPS  = 31;
    localparam int DIV_STEPS = 17;
    localparam int NUM_W     = 49;
    localparam int ONE_Q16   = 65536;

    typedef struct packed {
        logic signed [31:0] ax;
        logic signed [31:0] ay;
        logic [29:0]        ra;
        logic [30:0]        rsum;
        logic               sx;
        logic               sy;
        logic [31:0]        mdx;
        logic [31:0]        mdy;
        logic signed [32:0] rvx;
        logic signed [32:0] rvy;
        logic               dyn;
        logic               miss;
    } t_geo;

    function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
        logic signed [31:0] res;
        if (v > 64'sd2147483647) begin
            res = 32'sh7fffffff;
        end else if (v < -64'sd2147483648) begin
            res = 32'sh80000000;
        end else begin
            res = v[31:0];
        end
        return res;
    endfunction

    // divide by 2^16, halves away from zero
    function automatic logic signed [63:0] rnd16(input logic signed [63:0] v);
        logic [63:0] m;
        m = v[63] ? 64'(-v) : 64'(v);
        m = (m + 64'd32768) >> 16;
        return v[63] ? -$signed(m) : $signed(m);
    endfunction

endpackage

FILE: rtl/cpcc_sqrt.sv
// ----------------------------------------------------------------------------
// cpcc_sqrt
// Pipelined integer square root, one result bit per register stage.
// ----------------------------------------------------------------------------
module cpcc_sqrt (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  logic              i_vld,
    input  logic [61:0]       i_rad,
    input  cpcc_pkg::t_geo    i_geo,
    output logic              o_vld,
    output logic [30:0]       o_root,
    output cpcc_pkg::t_geo    o_geo
);

    logic [63:0]    r_v   [cpcc_pkg::SQ_STEPS+1];
    logic [63:0]    r_r   [cpcc_pkg::SQ_STEPS+1];
    cpcc_pkg::t_geo r_geo [cpcc_pkg::SQ_STEPS+1];
    logic           r_vld [cpcc_pkg::SQ_STEPS+1];

    always_comb begin
        r_v[0]   = {2'b00, i_rad};
        r_r[0]   = '0;
        r_geo[0] = i_geo;
        r_vld[0] = i_vld;
    end

    for (genvar j = 0; j < cpcc_pkg::SQ_STEPS; j++) begin : g_step
        logic [63:0] bitv;
        logic [63:0] trial;
        logic [63:0] n_v;
        logic [63:0] n_r;
        always_comb begin
            bitv  = 64'd1 << (2 * (cpcc_pkg::SQ_STEPS - 1 - j));
            trial = r_r[j] + bitv;
            if (r_v[j] >= trial) begin
                n_v = r_v[j] - trial;
                n_r = (r_r[j] >> 1) + bitv;
            end else begin
                n_v = r_v[j];
                n_r = r_r[j] >> 1;
            end
        end
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[j+1] <= 1'b0;
            end else if (i_en) begin
                r_vld[j+1] <= r_vld[j];
            end
            if (i_en) begin
                r_v[j+1]   <= n_v;
                r_r[j+1]   <= n_r;
                r_geo[j+1] <= r_geo[j];
            end
        end
    end

    assign o_vld  = r_vld[cpcc_pkg::SQ_STEPS];
    assign o_root = r_r[cpcc_pkg::SQ_STEPS][30:0];
    assign o_geo  = r_geo[cpcc_pkg::SQ_STEPS];

endmodule

FILE: rtl/circle_pair_collision_contact.sv
// ----------------------------------------------------------------------------
// circle_pair_collision_contact
// Circle pair overlap test with penetration, normal, contact and closing speed.
// ----------------------------------------------------------------------------
// Stages: 3 setup, 31 sqrt, 1 divide setup, 17 divide, 1 multiply,
//   1 output register + rounding.
// Throughput: one beat per cycle; the whole pipe stalls while the output
//   register holds an untaken beat.
// Reset: synchronous active-low clears all valid bits; payload is not reset.
module circle_pair_collision_contact (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_s_axis_tvalid,
    output logic                        o_s_axis_tready,
    // a_x, a_y, a_radius, b_x, b_y, b_radius, a_vel_x, a_vel_y,
    // b_vel_x, b_vel_y, a_dynamic, b_dynamic, 2 pad bits
    input  logic [cpcc_pkg::IN_W-1:0]   i_s_axis_tdata,
    output logic                        o_m_axis_tvalid,
    input  logic                        i_m_axis_tready,
    // hit, penetration, norm_x, norm_y, contact_x, contact_y,
    // closing_speed, 4 pad bits
    output logic [cpcc_pkg::OUT_W-1:0]  o_m_axis_tdata
);

    logic en;
    assign en = !o_m_axis_tvalid || i_m_axis_tready;
    assign o_s_axis_tready = en;

    // ---- stage 1: differences
    logic signed [31:0] in_ax, in_ay, in_bx, in_by, in_avx, in_avy, in_bvx, in_bvy;
    logic [29:0]        in_ra, in_rb;
    logic               in_adyn, in_bdyn;
    logic signed [32:0] dx, dy;
    cpcc_pkg::t_geo     n_g1, r_g1, r_g2, r_g3;
    logic               r_v1, r_v2, r_v3;

    always_comb begin
        in_ax   = i_s_axis_tdata[31:0];
        in_ay   = i_s_axis_tdata[63:32];
        in_ra   = i_s_axis_tdata[93:64];
        in_bx   = i_s_axis_tdata[125:94];
        in_by   = i_s_axis_tdata[157:126];
        in_rb   = i_s_axis_tdata[187:158];
        in_avx  = in_adyn ? i_s_axis_tdata[219:188] : '0;
        in_avy  = in_adyn ? i_s_axis_tdata[251:220] : '0;
        in_bvx  = in_bdyn ? i_s_axis_tdata[283:252] : '0;
        in_bvy  = in_bdyn ? i_s_axis_tdata[315:284] : '0;
        dx      = 33'(in_bx) - 33'(in_ax);
        dy      = 33'(in_by) - 33'(in_ay);
        n_g1.ax   = in_ax;
        n_g1.ay   = in_ay;
        n_g1.ra   = in_ra;
        n_g1.rsum = 31'(in_ra) + 31'(in_rb);
        n_g1.sx   = dx[32];
        n_g1.sy   = dy[32];
        n_g1.mdx  = dx[32] ? 32'(-dx) : dx[31:0];
        n_g1.mdy  = dy[32] ? 32'(-dy) : dy[31:0];
        n_g1.rvx  = 33'(in_bvx) - 33'(in_avx);
        n_g1.rvy  = 33'(in_bvy) - 33'(in_avy);
        n_g1.dyn  = in_adyn || in_bdyn;
        n_g1.miss = 1'b0;
    end
    assign in_adyn = i_s_axis_tdata[316];
    assign in_bdyn = i_s_axis_tdata[317];

    // ---- stage 2: squares, stage 3: overlap test
    logic [63:0] r_dx2, r_dy2;
    logic [61:0] r_r2, r_rad3;
    logic [64:0] sum2;
    cpcc_pkg::t_geo n_g3;

    always_comb begin
        sum2      = 65'(r_dx2) + 65'(r_dy2);
        n_g3      = r_g2;
        n_g3.miss = (r_dx2 >= 64'(r_r2)) || (r_dy2 >= 64'(r_r2)) || (sum2 >= 65'(r_r2));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else if (en) begin
            r_v1 <= i_s_axis_tvalid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
        if (en) begin
            r_g1   <= n_g1;
            r_dx2  <= r_g1.mdx * r_g1.mdx;
            r_dy2  <= r_g1.mdy * r_g1.mdy;
            r_r2   <= r_g1.rsum * r_g1.rsum;
            r_g2   <= r_g1;
            r_g3   <= n_g3;
            r_rad3 <= sum2[61:0];
        end
    end

    // ---- square root
    logic           sq_vld;
    logic [30:0]    sq_root;
    cpcc_pkg::t_geo sq_geo;

    cpcc_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_vld   (r_v3),
        .i_rad   (r_rad3),
        .i_geo   (r_g3),
        .o_vld   (sq_vld),
        .o_root  (sq_root),
        .o_geo   (sq_geo)
    );

    // ---- divide: u = round(|d| * 2^16 / len)
    logic [cpcc_pkg::NUM_W-1:0] r_remx [cpcc_pkg::DIV_STEPS+1];
    logic [cpcc_pkg::NUM_W-1:0] r_remy [cpcc_pkg::DIV_STEPS+1];
    logic [16:0]                r_qx   [cpcc_pkg::DIV_STEPS+1];
    logic [16:0]                r_qy   [cpcc_pkg::DIV_STEPS+1];
    logic [30:0]                r_len  [cpcc_pkg::DIV_STEPS+1];
    cpcc_pkg::t_geo             r_gd   [cpcc_pkg::DIV_STEPS+1];
    logic                       r_vd   [cpcc_pkg::DIV_STEPS+1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vd[0] <= 1'b0;
        end else if (en) begin
            r_vd[0] <= sq_vld;
        end
        if (en) begin
            r_remx[0] <= {1'b0, sq_geo.mdx, 16'd0} + cpcc_pkg::NUM_W'(sq_root >> 1);
            r_remy[0] <= {1'b0, sq_geo.mdy, 16'd0} + cpcc_pkg::NUM_W'(sq_root >> 1);
            r_qx[0]   <= '0;
            r_qy[0]   <= '0;
            r_len[0]  <= sq_root;
            r_gd[0]   <= sq_geo;
        end
    end

    for (genvar j = 0; j < cpcc_pkg::DIV_STEPS; j++) begin : g_div
        logic [cpcc_pkg::NUM_W-1:0] dsh;
        logic                       tx, ty;
        always_comb begin
            dsh = cpcc_pkg::NUM_W'(r_len[j]) << (cpcc_pkg::DIV_STEPS - 1 - j);
            tx  = r_remx[j] >= dsh;
            ty  = r_remy[j] >= dsh;
        end
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vd[j+1] <= 1'b0;
            end else if (en) begin
                r_vd[j+1] <= r_vd[j];
            end
            if (en) begin
                r_remx[j+1] <= tx ? r_remx[j] - dsh : r_remx[j];
                r_remy[j+1] <= ty ? r_remy[j] - dsh : r_remy[j];
                r_qx[j+1]   <= {r_qx[j][15:0], tx};
                r_qy[j+1]   <= {r_qy[j][15:0], ty};
                r_len[j+1]  <= r_len[j];
                r_gd[j+1]   <= r_gd[j];
            end
        end
    end

    // ---- multiply stage
    localparam int DL = cpcc_pkg::DIV_STEPS;
    logic signed [17:0] ux, uy, nx, ny;
    logic               zero_len;
    logic signed [47:0] r_pcx, r_pcy;
    logic signed [50:0] r_psx, r_psy;
    logic signed [17:0] r_nx, r_ny;
    logic [30:0]        r_pen;
    logic               r_zero, r_vm;
    cpcc_pkg::t_geo     r_gm;

    always_comb begin
        zero_len = (r_len[DL] == '0);
        if (zero_len) begin
            ux = 18'(cpcc_pkg::ONE_Q16);
            uy = '0;
        end else begin
            ux = r_gd[DL].sx ? -$signed({1'b0, r_qx[DL]}) : $signed({1'b0, r_qx[DL]});
            uy = r_gd[DL].sy ? -$signed({1'b0, r_qy[DL]}) : $signed({1'b0, r_qy[DL]});
        end
        nx = -ux;
        ny = -uy;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vm <= 1'b0;
        end else if (en) begin
            r_vm <= r_vd[DL];
        end
        if (en) begin
            r_pcx  <= 48'(ux) * $signed({1'b0, r_gd[DL].ra});
            r_pcy  <= 48'(uy) * $signed({1'b0, r_gd[DL].ra});
            r_psx  <= 51'(r_gd[DL].rvx) * 51'(nx);
            r_psy  <= 51'(r_gd[DL].rvy) * 51'(ny);
            r_nx   <= nx;
            r_ny   <= ny;
            r_pen  <= zero_len ? 31'(r_gd[DL].ra) : r_gd[DL].rsum - r_len[DL];
            r_zero <= zero_len;
            r_gm   <= r_gd[DL];
        end
    end

    // ---- rounding, saturation, output register
    logic signed [31:0] cx, cy, speed;
    logic               hit;
    logic               r_out_vld;
    logic [cpcc_pkg::OUT_W-1:0] r_out;

    always_comb begin
        cx = r_zero ? r_gm.ax :
             cpcc_pkg::sat32(64'(r_gm.ax) + cpcc_pkg::rnd16(64'(r_pcx)));
        cy = r_zero ? r_gm.ay :
             cpcc_pkg::sat32(64'(r_gm.ay) + cpcc_pkg::rnd16(64'(r_pcy)));
        speed = cpcc_pkg::sat32(cpcc_pkg::rnd16(64'(r_psx) + 64'(r_psy)));
        hit   = !(r_gm.dyn && speed <= 0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (en) begin
            r_out_vld <= r_vm;
        end
        if (en) begin
            if (r_gm.miss) begin
                r_out <= '0;
            end else begin
                r_out <= {4'd0, speed, cy, cx, r_ny, r_nx, r_pen, hit};
            end
        end
    end

    assign o_m_axis_tvalid = r_out_vld;
    assign o_m_axis_tdata  = r_out;

    // ---- checks
    a_reset_clears: assert property (@(posedge i_clk)
        !$past(i_rst_n) |-> !o_m_axis_tvalid)
        else $error("output valid after reset");

    a_nx_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> ($signed(o_m_axis_tdata[49:32]) <= 18'sd65536 &&
                             $signed(o_m_axis_tdata[49:32]) >= -18'sd65536))
        else $error("norm_x out of range");

    a_ny_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> ($signed(o_m_axis_tdata[67:50]) <= 18'sd65536 &&
                             $signed(o_m_axis_tdata[67:50]) >= -18'sd65536))
        else $error("norm_y out of range");

    a_hit_normal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && o_m_axis_tdata[0]) |->
            (o_m_axis_tdata[49:32] != '0 || o_m_axis_tdata[67:50] != '0))
        else $error("hit with zero normal");

endmodule

FILE: bench/contact_checker.sv
// ----------------------------------------------------------------------------
// contact_checker
// Watches both stream channels of the circle contact block, predicts each
// contact result from the accepted circle pair and compares it field by field.
// ----------------------------------------------------------------------------
module contact_checker (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_s_valid,
    input  logic                       i_s_ready,
    input  logic [cpcc_pkg::IN_W-1:0]  i_s_data,
    input  logic                       i_m_valid,
    input  logic                       i_m_ready,
    input  logic [cpcc_pkg::OUT_W-1:0] i_m_data,
    output int                         o_errors,
    output int                         o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    // highest field first, so hit lands in bit 0
    typedef struct packed {
        logic signed [31:0] speed;
        logic signed [31:0] cy;
        logic signed [31:0] cx;
        logic signed [17:0] ny;
        logic signed [17:0] nx;
        logic [30:0]        pen;
        logic               hit;
    } t_contact;

    t_contact contact_q[$];

    function automatic longint clamp32(input longint v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    function automatic longint round_q16(input longint v);
        longint m;
        m = v < 0 ? -v : v;
        m = (m + 32768) >>> 16;
        return v < 0 ? -m : m;
    endfunction

    function automatic longint unsigned root64(input longint unsigned v);
        longint unsigned r, b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v) b = b >> 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    function automatic longint unit_q16(input longint num, input longint unsigned den);
        longint unsigned m, q;
        m = num < 0 ? -num : num;
        q = ((m << 16) + den / 2) / den;
        return num < 0 ? -longint'(q) : longint'(q);
    endfunction

    function automatic t_contact predict_contact(input logic [cpcc_pkg::IN_W-1:0] d);
        t_contact r;
        longint ax, ay, bx, by, avx, avy, bvx, bvy, dx, dy, ux, uy, cx, cy, sp;
        longint unsigned ra, rb, mdx, mdy, dx2, dy2, rs, r2, len, pen;
        logic adyn, bdyn;
        ax = longint'($signed(d[31:0]));
        ay = longint'($signed(d[63:32]));
        ra = 64'(d[93:64]);
        bx = longint'($signed(d[125:94]));
        by = longint'($signed(d[157:126]));
        rb = 64'(d[187:158]);
        adyn = d[316];
        bdyn = d[317];
        avx = adyn ? longint'($signed(d[219:188])) : 0;
        avy = adyn ? longint'($signed(d[251:220])) : 0;
        bvx = bdyn ? longint'($signed(d[283:252])) : 0;
        bvy = bdyn ? longint'($signed(d[315:284])) : 0;
        r = '0;
        dx = bx - ax;
        dy = by - ay;
        mdx = dx < 0 ? -dx : dx;
        mdy = dy < 0 ? -dy : dy;
        dx2 = mdx * mdx;
        dy2 = mdy * mdy;
        rs = ra + rb;
        r2 = rs * rs;
        if (dx2 >= r2 || dy2 >= r2 || dx2 + dy2 >= r2) return r;
        len = root64(dx2 + dy2);
        if (len == 0) begin
            pen = ra;
            ux = 65536;
            uy = 0;
            cx = ax;
            cy = ay;
        end else begin
            pen = rs - len;
            ux = unit_q16(dx, len);
            uy = unit_q16(dy, len);
            cx = clamp32(ax + round_q16(ux * longint'(ra)));
            cy = clamp32(ay + round_q16(uy * longint'(ra)));
        end
        sp = clamp32(round_q16((bvx - avx) * (-ux) + (bvy - avy) * (-uy)));
        r.hit = ((adyn || bdyn) && sp <= 0) ? 1'b0 : 1'b1;
        r.pen = pen[30:0];
        r.nx = 18'(-ux);
        r.ny = 18'(-uy);
        r.cx = 32'(cx);
        r.cy = 32'(cy);
        r.speed = 32'(sp);
        return r;
    endfunction

    task automatic check_field(input string name, input longint e, input longint a);
        if (e != a) begin
            $error("%s: expected %0d, got %0d", name, e, a);
            o_errors++;
        end
    endtask

    initial o_errors = 0;
    assign o_pending = contact_q.size();

    always @(posedge i_clk) begin
        t_contact e, a;
        if (i_rst_n && i_s_valid && i_s_ready) contact_q.push_back(predict_contact(i_s_data));
        if (i_rst_n && i_m_valid && i_m_ready) begin
            a = i_m_data[163:0];
            if (contact_q.size() == 0) begin
                $error("unexpected result beat");
                o_errors++;
            end else begin
                e = contact_q.pop_front();
                check_field("hit", e.hit, a.hit);
                check_field("penetration", e.pen, a.pen);
                check_field("norm_x", e.nx, a.nx);
                check_field("norm_y", e.ny, a.ny);
                check_field("contact_x", e.cx, a.cx);
                check_field("contact_y", e.cy, a.cy);
                check_field("closing_speed", e.speed, a.speed);
            end
        end
    end
endmodule

FILE: bench/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Drives circle pairs into the contact block under several idle and stall
// mixes; the checker predicts and compares every contact result.
// ----------------------------------------------------------------------------
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int LIMIT = 400000;

    logic                       i_clk;
    logic                       i_rst_n;
    logic                       s_valid;
    logic                       s_ready;
    logic [cpcc_pkg::IN_W-1:0]  s_data;
    logic                       m_valid;
    logic                       m_ready;
    logic [cpcc_pkg::OUT_W-1:0] m_data;
    int                         errors;
    int                         pending;
    int                         cycles;
    int                         send_idle;
    int                         recv_stall;

    circle_pair_collision_contact u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_valid),
        .o_s_axis_tready (s_ready),
        .i_s_axis_tdata  (s_data),
        .o_m_axis_tvalid (m_valid),
        .i_m_axis_tready (m_ready),
        .o_m_axis_tdata  (m_data)
    );

    contact_checker u_checker (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_s_valid (s_valid),
        .i_s_ready (s_ready),
        .i_s_data  (s_data),
        .i_m_valid (m_valid),
        .i_m_ready (m_ready),
        .i_m_data  (m_data),
        .o_errors  (errors),
        .o_pending (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        m_ready <= ($urandom_range(99) >= recv_stall);
        if (cycles > LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    function automatic logic [31:0] pick_coord(input int mode);
        case (mode)
            0: return $urandom;
            1: return 32'(int'($urandom_range(400000)) - 200000);
            2: return $urandom_range(1) ? 32'h7fffffff : 32'h80000000;
            default: return 32'(int'($urandom_range(2000)) - 1000);
        endcase
    endfunction

    function automatic logic [cpcc_pkg::IN_W-1:0] make_pair();
        logic [31:0] ax, ay, bx, by;
        logic [29:0] ra, rb;
        int m;
        m = $urandom_range(9);
        ax = pick_coord(m < 2 ? 0 : (m < 7 ? 1 : (m == 7 ? 2 : 3)));
        ay = pick_coord(m < 2 ? 0 : (m < 7 ? 1 : (m == 7 ? 2 : 3)));
        bx = ax + pick_coord(m < 5 ? 1 : 3);
        by = ay + pick_coord(m < 5 ? 1 : 3);
        if ($urandom_range(15) == 0) begin
            bx = ax;
            by = ay;
        end
        if (m < 2) begin
            ra = 30'($urandom);
            rb = 30'($urandom);
        end else if (m == 7) begin
            ra = 30'(30'h3fffffff - $urandom_range(3));
            rb = $urandom_range(1) ? 30'h3fffffff : 30'h0;
        end else begin
            ra = 30'($urandom_range(200000));
            rb = 30'($urandom_range(200000));
        end
        return {2'b00, 2'($urandom), 32'($urandom), 32'($urandom), 32'($urandom),
                32'($urandom), rb, by, bx, ra, ay, ax};
    endfunction

    task automatic send_beat(input logic [cpcc_pkg::IN_W-1:0] d);
        while ($urandom_range(99) < send_idle) begin
            s_valid <= 1'b0;
            @(posedge i_clk);
        end
        s_valid <= 1'b1;
        s_data <= d;
        @(posedge i_clk);
        while (!s_ready) @(posedge i_clk);
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
    endtask

    initial begin
        logic [31:0] c;
        cycles = 0;
        send_idle = 0;
        recv_stall = 0;
        s_valid = 1'b0;
        s_data = '0;
        m_ready = 1'b1;
        i_rst_n = 1'b0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        // directed: extremes, coincident centres, static bodies, separation
        send_beat('0);
        send_beat({2'b00, 2'b11, {4{32'hffffffff}}, {30{1'b1}}, {64{1'b1}}, {30{1'b1}},
                   {64{1'b1}}});
        send_beat({2'b00, 2'b00, 128'h0, 30'd65536, 32'd0, 32'd65536, 30'd65536, 32'd0,
                   32'd0});
        send_beat({2'b00, 2'b01, 32'd0, 32'd0, 32'h80000000, 32'h7fffffff, 30'h3fffffff,
                   32'h7fffffff, 32'h7fffffff, 30'h3fffffff, 32'h7fffffff, 32'h7ffff000});
        send_beat({2'b00, 2'b10, 32'h80000000, 32'h7fffffff, 64'h0, 30'h3fffffff,
                   32'h80000000, 32'h80000000, 30'h3fffffff, 32'h80000100, 32'h80000000});
        send_beat({2'b00, 2'b11, 32'd0, 32'h10000, 32'd0, 32'hffff0000, 30'd100000,
                   32'd0, 32'd50000, 30'd100000, 32'd0, 32'd0});
        send_beat({2'b00, 2'b11, 32'd0, 32'hffff0000, 32'd0, 32'h10000, 30'd100000,
                   32'd0, 32'd50000, 30'd100000, 32'd0, 32'd0});
        send_beat({2'b00, 2'b01, 128'h0, 30'd5, 32'd3, 32'd4, 30'd5, 32'd0, 32'd0});
        send_beat({2'b00, 2'b10, 32'h7fffffff, 32'h80000000, 64'h0, 30'h3fffffff,
                   32'h7fffffff, 32'h7fffffff, 30'h3fffffff, 32'h7fffffff, 32'h7fffff00});
        for (int i = 0; i < 10; i++) begin
            c = $urandom;
            send_beat({2'b00, 2'($urandom), 128'({$urandom, $urandom, $urandom, $urandom}),
                       30'($urandom), c, c, 30'($urandom), c, c});
        end
        drain();
        for (int p = 0; p < 5; p++) begin
            send_idle = (p == 1 || p == 4) ? 59 : (p == 3 ? 17 : 0);
            recv_stall = (p == 2 || p == 4) ? 59 : (p == 3 ? 17 : 0);
            for (int i = 0; i < 320; i++) send_beat(make_pair());
            if (p == 2) drain();
        end
        drain();
        repeat (80) @(posedge i_clk);
        if (errors == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end
endmodule
